### hdl/poly7_path_coefficients_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros for the septic path coefficient block
// Shared clocked, reset-qualified property forms.
// ----------------------------------------------------------------------------
`ifndef POLY7_PATH_COEFFICIENTS_MACROS_SVH
`define POLY7_PATH_COEFFICIENTS_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define P7PC_ASSERT_NOW(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
    else $error("p7pc assertion failed");

// Next-cycle implication, disabled while reset is asserted.
`define P7PC_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
    else $error("p7pc assertion failed");

`endif

### hdl/p7pc_pkg.sv
// ----------------------------------------------------------------------------
// p7pc_pkg
// Widths, constants, types and helper functions of the path coefficient block.
// ----------------------------------------------------------------------------
`default_nettype none

package p7pc_pkg;

  localparam int CordicSteps = 16;
  localparam int FracBits    = 16;

  localparam int AngW   = 16;
  localparam int PosW   = 32;
  localparam int CoefW  = 48;
  localparam int NumCoef = 8;
  localparam int IdxW   = 3;
  localparam logic [IdxW-1:0] LastIdx = IdxW'(NumCoef - 1);

  // CORDIC angle and vector widths (Q30 with headroom).
  localparam int ZW = 35;
  localparam int XW = 34;
  localparam int RShift = 30 - FracBits;

  localparam int TrigW  = FracBits + 2;
  localparam int ProdW  = PosW + TrigW;
  localparam int TermW  = ProdW + 8;
  localparam int DiffW  = PosW + 1;
  localparam int DTermW = DiffW + 8;
  localparam int RW     = CoefW + 2;

  localparam logic signed [ZW-1:0] PiQ30     = ZW'(64'sd3373259426);
  localparam logic signed [ZW-1:0] HalfPiQ30 = ZW'(64'sd1686629713);
  localparam logic signed [XW-1:0] GainQ30   = XW'(64'sd652032874);

  // Per-item values that travel beside the CORDIC.
  typedef struct packed {
    logic signed [PosW-1:0]  sx;
    logic signed [PosW-1:0]  sy;
    logic signed [PosW-1:0]  n1;
    logic signed [PosW-1:0]  n2;
    logic signed [DiffW-1:0] dx;
    logic signed [DiffW-1:0] dy;
  } side_t;

  typedef struct packed {
    logic signed [CoefW-1:0] x;
    logic signed [CoefW-1:0] y;
  } pair_t;

  // atan(2^-i) in Q30, rounded to nearest.
  function automatic logic signed [ZW-1:0] atan_q30(input int unsigned i);
    case (i)
      0:  return ZW'(64'sd843314857);
      1:  return ZW'(64'sd497837829);
      2:  return ZW'(64'sd263043837);
      3:  return ZW'(64'sd133525159);
      4:  return ZW'(64'sd67021687);
      5:  return ZW'(64'sd33543516);
      6:  return ZW'(64'sd16775851);
      7:  return ZW'(64'sd8388437);
      8:  return ZW'(64'sd4194283);
      9:  return ZW'(64'sd2097149);
      10: return ZW'(64'sd1048576);
      11: return ZW'(64'sd524288);
      12: return ZW'(64'sd262144);
      13: return ZW'(64'sd131072);
      14: return ZW'(64'sd65536);
      15: return ZW'(64'sd32768);
      16: return ZW'(64'sd16384);
      17: return ZW'(64'sd8192);
      18: return ZW'(64'sd4096);
      19: return ZW'(64'sd2048);
      20: return ZW'(64'sd1024);
      21: return ZW'(64'sd512);
      22: return ZW'(64'sd256);
      23: return ZW'(64'sd128);
      24: return ZW'(64'sd64);
      25: return ZW'(64'sd32);
      26: return ZW'(64'sd16);
      27: return ZW'(64'sd8);
      28: return ZW'(64'sd4);
      29: return ZW'(64'sd2);
      default: return '0;
    endcase
  endfunction

  // Weights of the position difference for coefficients four to seven.
  function automatic logic signed [7:0] kd_w(input int unsigned k);
    case (k)
      0: return 8'sd35;
      1: return -8'sd84;
      2: return 8'sd70;
      3: return -8'sd20;
      default: return '0;
    endcase
  endfunction

  // Weights of the start tangent term.
  function automatic logic signed [7:0] k1_w(input int unsigned k);
    case (k)
      0: return -8'sd20;
      1: return 8'sd45;
      2: return -8'sd36;
      3: return 8'sd10;
      default: return '0;
    endcase
  endfunction

  // Weights of the end tangent term.
  function automatic logic signed [7:0] k2_w(input int unsigned k);
    case (k)
      0: return -8'sd15;
      1: return 8'sd39;
      2: return -8'sd34;
      3: return 8'sd10;
      default: return '0;
    endcase
  endfunction

  // Round from Q.(16+FracBits) to Q16, ties toward plus infinity.
  function automatic logic signed [TermW-1:0] rnd_frac(input logic signed [TermW-1:0] v);
    logic signed [TermW-1:0] half;
    half = TermW'(1) <<< (FracBits - 1);
    return (v + half) >>> FracBits;
  endfunction

  // Saturate to the signed coefficient range.
  function automatic logic signed [CoefW-1:0] sat_coef(input logic signed [RW-1:0] v);
    logic signed [RW-1:0] hi;
    logic signed [RW-1:0] lo;
    hi = RW'($signed({1'b0, {(CoefW-1){1'b1}}}));
    lo = -hi - RW'(1);
    if (v > hi) begin
      return hi[CoefW-1:0];
    end else if (v < lo) begin
      return lo[CoefW-1:0];
    end
    return v[CoefW-1:0];
  endfunction

endpackage

`default_nettype wire

### hdl/poly7_path_coefficients.sv
// ----------------------------------------------------------------------------
// poly7_path_coefficients
// Seventh-degree path polynomial coefficients from two poses and two gains.
// ----------------------------------------------------------------------------
//
//   Channel  Direction  Handshake                 Payload
//   in       sink       in_valid_i / in_ready_o   two poses, two gains
//   out      source     out_valid_o / out_ready_i index, x/y coefficient, last
//
// An accepted item passes the CORDIC, the three coefficient stages and the output
// buffer in order. Each item yields eight results, one per cycle while out_ready_i
// is high; the single result port of the output buffer sets the sustained rate.
// The whole pipeline advances on one enable; a stall on the result side
// freezes every stage, so nothing is lost or repeated.
// Reset clears valid bits and the output index only.
// ----------------------------------------------------------------------------
`default_nettype none

module poly7_path_coefficients (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               in_valid_i,
  output logic                               in_ready_o,
  input  logic signed [p7pc_pkg::PosW-1:0]   start_x_i,
  input  logic signed [p7pc_pkg::PosW-1:0]   start_y_i,
  input  logic signed [p7pc_pkg::AngW-1:0]   start_heading_i,
  input  logic signed [p7pc_pkg::PosW-1:0]   end_x_i,
  input  logic signed [p7pc_pkg::PosW-1:0]   end_y_i,
  input  logic signed [p7pc_pkg::AngW-1:0]   end_heading_i,
  input  logic signed [p7pc_pkg::PosW-1:0]   start_gain_i,
  input  logic signed [p7pc_pkg::PosW-1:0]   end_gain_i,
  output logic                               out_valid_o,
  input  logic                               out_ready_i,
  output logic [p7pc_pkg::IdxW-1:0]          coef_index_o,
  output logic signed [p7pc_pkg::CoefW-1:0]  x_coef_o,
  output logic signed [p7pc_pkg::CoefW-1:0]  y_coef_o,
  output logic                               last_coef_o
);
  import p7pc_pkg::*;

  logic                    adv;
  side_t                   side_in;
  logic signed [AngW-1:0]  ang [2];
  logic                    cv;
  logic signed [TrigW-1:0] cs_cos [2];
  logic signed [TrigW-1:0] cs_sin [2];
  side_t                   cs_side;
  logic                    kv;
  pair_t                   kcoef [NumCoef];

  pair_t                   buf_q [NumCoef];
  logic                    busy_q;
  logic [IdxW-1:0]         idx_q;

  // The pipeline moves when the output buffer is empty or hands off its last result.
  assign adv        = !busy_q || (out_ready_i && (idx_q == LastIdx));
  assign in_ready_o = adv;

  assign ang[0] = start_heading_i;
  assign ang[1] = end_heading_i;

  always_comb begin
    side_in.sx = start_x_i;
    side_in.sy = start_y_i;
    side_in.n1 = start_gain_i;
    side_in.n2 = end_gain_i;
    side_in.dx = DiffW'(end_x_i) - DiffW'(start_x_i);
    side_in.dy = DiffW'(end_y_i) - DiffW'(start_y_i);
  end

  p7pc_cordic u_cordic (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (adv),
    .valid_i (in_valid_i),
    .ang_i   (ang),
    .side_i  (side_in),
    .valid_o (cv),
    .cos_o   (cs_cos),
    .sin_o   (cs_sin),
    .side_o  (cs_side)
  );

  p7pc_coef u_coef (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (adv),
    .valid_i (cv),
    .cos_i   (cs_cos),
    .sin_i   (cs_sin),
    .side_i  (cs_side),
    .valid_o (kv),
    .coef_o  (kcoef)
  );

  // Output buffer payload.
  always_ff @(posedge clk_i) begin
    if (adv) begin
      buf_q <= kcoef;
    end
  end

  // Output buffer control: one result per transaction, index order.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      idx_q  <= '0;
    end else if (adv) begin
      busy_q <= kv;
      idx_q  <= '0;
    end else if (out_ready_i) begin
      idx_q  <= idx_q + IdxW'(1);
    end
  end

  assign out_valid_o  = busy_q;
  assign coef_index_o = idx_q;
  assign x_coef_o     = buf_q[idx_q].x;
  assign y_coef_o     = buf_q[idx_q].y;
  assign last_coef_o  = (idx_q == LastIdx);

`include "poly7_path_coefficients_macros.svh"

  // A held result blocks new input.
  `P7PC_ASSERT_NOW(a_hold_blocks_input, clk_i, rst_ni, out_valid_o && !(out_ready_i && last_coef_o), !in_ready_o)
  // Results step through the indices one at a time.
  `P7PC_ASSERT_NEXT(a_index_steps, clk_i, rst_ni, out_valid_o && out_ready_i && !last_coef_o, out_valid_o && (coef_index_o == $past(coef_index_o) + 1))
  // The quadratic and cubic pairs are zero.
  `P7PC_ASSERT_NOW(a_mid_zero, clk_i, rst_ni, out_valid_o && (coef_index_o == 3'd2 || coef_index_o == 3'd3), x_coef_o == 0 && y_coef_o == 0)

endmodule

`default_nettype wire

### hdl/p7pc_cordic.sv
// ----------------------------------------------------------------------------
// p7pc_cordic
// Two-lane pipelined rotation CORDIC: cosine and sine of both headings.
// ----------------------------------------------------------------------------
`default_nettype none

module p7pc_cordic (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  logic                                  en_i,
  input  logic                                  valid_i,
  input  logic signed [p7pc_pkg::AngW-1:0]      ang_i [2],
  input  p7pc_pkg::side_t                       side_i,
  output logic                                  valid_o,
  output logic signed [p7pc_pkg::TrigW-1:0]     cos_o [2],
  output logic signed [p7pc_pkg::TrigW-1:0]     sin_o [2],
  output p7pc_pkg::side_t                       side_o
);
  import p7pc_pkg::*;

  localparam int Depth = CordicSteps + 2;

  logic signed [XW-1:0] x_q [2][CordicSteps+1];
  logic signed [XW-1:0] x_d [2][CordicSteps+1];
  logic signed [XW-1:0] y_q [2][CordicSteps+1];
  logic signed [XW-1:0] y_d [2][CordicSteps+1];
  logic signed [ZW-1:0] z_q [2][CordicSteps+1];
  logic signed [ZW-1:0] z_d [2][CordicSteps+1];
  logic                 neg_q [2][CordicSteps+1];
  logic                 neg_d [2][CordicSteps+1];

  logic signed [TrigW-1:0] cos_q [2];
  logic signed [TrigW-1:0] cos_d [2];
  logic signed [TrigW-1:0] sin_q [2];
  logic signed [TrigW-1:0] sin_d [2];

  logic  valid_q [Depth];
  side_t side_q  [Depth];

  // Range fold, micro-rotations and final rounding.
  always_comb begin
    logic signed [ZW-1:0] z0;
    logic signed [XW-1:0] xf;
    logic signed [XW-1:0] yf;
    logic signed [XW-1:0] half;
    half = XW'(1) <<< (RShift - 1);
    for (int l = 0; l < 2; l++) begin
      // Headings beyond a quarter turn are folded by pi and negated at the end.
      z0 = {{(ZW-AngW-17){ang_i[l][AngW-1]}}, ang_i[l], 17'b0};
      x_d[l][0] = GainQ30;
      y_d[l][0] = '0;
      if (z0 > HalfPiQ30) begin
        z_d[l][0]   = z0 - PiQ30;
        neg_d[l][0] = 1'b1;
      end else if (z0 < -HalfPiQ30) begin
        z_d[l][0]   = z0 + PiQ30;
        neg_d[l][0] = 1'b1;
      end else begin
        z_d[l][0]   = z0;
        neg_d[l][0] = 1'b0;
      end
      for (int s = 0; s < CordicSteps; s++) begin
        neg_d[l][s+1] = neg_q[l][s];
        if (z_q[l][s] >= 0) begin
          x_d[l][s+1] = x_q[l][s] - (y_q[l][s] >>> s);
          y_d[l][s+1] = y_q[l][s] + (x_q[l][s] >>> s);
          z_d[l][s+1] = z_q[l][s] - atan_q30(s);
        end else begin
          x_d[l][s+1] = x_q[l][s] + (y_q[l][s] >>> s);
          y_d[l][s+1] = y_q[l][s] - (x_q[l][s] >>> s);
          z_d[l][s+1] = z_q[l][s] + atan_q30(s);
        end
      end
      xf = neg_q[l][CordicSteps] ? -x_q[l][CordicSteps] : x_q[l][CordicSteps];
      yf = neg_q[l][CordicSteps] ? -y_q[l][CordicSteps] : y_q[l][CordicSteps];
      cos_d[l] = TrigW'((xf + half) >>> RShift);
      sin_d[l] = TrigW'((yf + half) >>> RShift);
    end
  end

  // Datapath registers advance together under the global enable.
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      x_q     <= x_d;
      y_q     <= y_d;
      z_q     <= z_d;
      neg_q   <= neg_d;
      cos_q   <= cos_d;
      sin_q   <= sin_d;
      side_q[0] <= side_i;
      for (int s = 1; s < Depth; s++) begin
        side_q[s] <= side_q[s-1];
      end
    end
  end

  // Valid bits travel with the data.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int s = 0; s < Depth; s++) begin
        valid_q[s] <= 1'b0;
      end
    end else if (en_i) begin
      valid_q[0] <= valid_i;
      for (int s = 1; s < Depth; s++) begin
        valid_q[s] <= valid_q[s-1];
      end
    end
  end

  assign valid_o = valid_q[Depth-1];
  assign side_o  = side_q[Depth-1];
  assign cos_o   = cos_q;
  assign sin_o   = sin_q;

endmodule

`default_nettype wire

### hdl/p7pc_coef.sv
// ----------------------------------------------------------------------------
// p7pc_coef
// Three-stage coefficient datapath: tangent products, weighted terms, sums.
// ----------------------------------------------------------------------------
`default_nettype none

module p7pc_coef (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              en_i,
  input  logic                              valid_i,
  input  logic signed [p7pc_pkg::TrigW-1:0] cos_i [2],
  input  logic signed [p7pc_pkg::TrigW-1:0] sin_i [2],
  input  p7pc_pkg::side_t                   side_i,
  output logic                              valid_o,
  output p7pc_pkg::pair_t                   coef_o [p7pc_pkg::NumCoef]
);
  import p7pc_pkg::*;

  // Product stage.
  logic signed [ProdW-1:0] px1_q, py1_q, px2_q, py2_q;
  side_t                   sp_q;
  logic                    vp_q;

  // Weighted term stage.
  logic signed [TermW-1:0]  wx_q [4];
  logic signed [TermW-1:0]  wy_q [4];
  logic signed [DTermW-1:0] dtx_q [4];
  logic signed [DTermW-1:0] dty_q [4];
  logic signed [TermW-1:0]  r1x_q, r1y_q;
  logic signed [PosW-1:0]   sxt_q, syt_q;
  logic                     vt_q;

  // Sum stage.
  pair_t coef_q [NumCoef];
  logic  vc_q;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      // Gain times trig products, exact.
      px1_q <= ProdW'(side_i.n1) * ProdW'(cos_i[0]);
      py1_q <= ProdW'(side_i.n1) * ProdW'(sin_i[0]);
      px2_q <= ProdW'(side_i.n2) * ProdW'(cos_i[1]);
      py2_q <= ProdW'(side_i.n2) * ProdW'(sin_i[1]);
      sp_q  <= side_i;

      // Constant-weighted tangent sums and difference terms.
      for (int k = 0; k < 4; k++) begin
        wx_q[k]  <= TermW'(k1_w(k)) * TermW'(px1_q) + TermW'(k2_w(k)) * TermW'(px2_q);
        wy_q[k]  <= TermW'(k1_w(k)) * TermW'(py1_q) + TermW'(k2_w(k)) * TermW'(py2_q);
        dtx_q[k] <= DTermW'(kd_w(k)) * DTermW'(sp_q.dx);
        dty_q[k] <= DTermW'(kd_w(k)) * DTermW'(sp_q.dy);
      end
      r1x_q <= rnd_frac(TermW'(px1_q));
      r1y_q <= rnd_frac(TermW'(py1_q));
      sxt_q <= sp_q.sx;
      syt_q <= sp_q.sy;

      // Start position, zero middle pairs, and rounded, saturated terms and sums.
      coef_q[0].x <= CoefW'(sxt_q);
      coef_q[0].y <= CoefW'(syt_q);
      coef_q[1].x <= sat_coef(RW'(r1x_q));
      coef_q[1].y <= sat_coef(RW'(r1y_q));
      coef_q[2]   <= '0;
      coef_q[3]   <= '0;
      for (int k = 0; k < 4; k++) begin
        coef_q[k+4].x <= sat_coef(RW'(dtx_q[k]) + RW'(rnd_frac(wx_q[k])));
        coef_q[k+4].y <= sat_coef(RW'(dty_q[k]) + RW'(rnd_frac(wy_q[k])));
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vp_q <= 1'b0;
      vt_q <= 1'b0;
      vc_q <= 1'b0;
    end else if (en_i) begin
      vp_q <= valid_i;
      vt_q <= vp_q;
      vc_q <= vt_q;
    end
  end

  assign valid_o = vc_q;
  assign coef_o  = coef_q;

endmodule

`default_nettype wire
